// ===== src/ble_pkg.sv =====
`timescale 1ns / 1ps

package ble_pkg;

  localparam int VALUE_W = 32;
  localparam int KIND_W  = 3;
  localparam int COUNT_W = 7;

  // Operation codes carried by the input kind field
  localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REM_VALUE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REM_FRONT = 3'd4;
  localparam logic [KIND_W-1:0] KIND_REM_BACK  = 3'd5;

  // Actions broadcast to every cell of the row
  localparam logic [2:0] ACT_HOLD     = 3'd0;
  localparam logic [2:0] ACT_SHIFT_R  = 3'd1;
  localparam logic [2:0] ACT_PUT_TAIL = 3'd2;
  localparam logic [2:0] ACT_SHL_HIT  = 3'd3;
  localparam logic [2:0] ACT_SHIFT_L  = 3'd4;

  typedef struct packed {
    logic               cmp;
    logic [2:0]         act;
    logic [VALUE_W-1:0] value;
  } ble_cmd_t;

endpackage

// ===== src/ble_cell.sv =====
`timescale 1ns / 1ps

module ble_cell import ble_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int IDX   = 0
) (
  input  logic                           clk,
  input  ble_cmd_t                       cmd,
  input  logic [$clog2(DEPTH+1)-1:0]     count,
  input  logic [VALUE_W-1:0]             left_in,
  input  logic [VALUE_W-1:0]             right_in,
  input  logic                           hit_before,
  output logic [VALUE_W-1:0]             entry,
  output logic                           match
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [VALUE_W-1:0] entry_r, entry_nxt;
  logic               match_r, match_nxt;

  always_comb begin
    entry_nxt = entry_r;
    match_nxt = match_r;
    if (cmd.cmp) begin
      match_nxt = (MY_IDX < count) && (entry_r == cmd.value);
    end
    case (cmd.act)
      ACT_SHIFT_R:  entry_nxt = left_in;
      ACT_PUT_TAIL: begin
        if (MY_IDX == count) entry_nxt = cmd.value;
      end
      ACT_SHL_HIT:  begin
        // close up from the first hit onward
        if (hit_before || match_r) entry_nxt = right_in;
      end
      ACT_SHIFT_L:  entry_nxt = right_in;
      default:      entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    match_r <= match_nxt;
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

// ===== src/bounded_list_engine.sv =====
`timescale 1ns / 1ps
// An input transfer passes through the compare state and then the apply state before the result is registered as valid.
// A new input is taken only in the idle state, once the compare-then-apply pass over the cell row is done.
// A waiting result does not block the next input transfer; apply stalls until it is taken.
// Reset (rst_n, synchronous, active low) empties the list and clears the handshakes.
// Entry storage is not reset; only positions below the count are ever looked at.
module bounded_list_engine import ble_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_ok,
  output logic [COUNT_W-1:0] out_count
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [KIND_W-1:0]  kind_r;
  logic [VALUE_W-1:0] value_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r;
  logic [COUNT_W-1:0] out_count_r;

  logic               in_xfer;
  logic               apply_fire;
  logic               found;
  logic               ok;
  logic [2:0]         act;
  ble_cmd_t           cmd;

  logic [VALUE_W-1:0] entry_w [DEPTH];
  logic [DEPTH-1:0]   match_w;
  logic [DEPTH-1:0]   hit_before_w;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_xfer    = in_valid && in_ready;
  // hold the apply step while the previous result still waits
  assign apply_fire = (state_r == ST_APPLY) && (!out_valid_r || out_ready);
  assign found      = |match_w;

  // Decide the action and the new count from the kind and the compare outcome
  always_comb begin
    ok        = 1'b0;
    act       = ACT_HOLD;
    count_nxt = count_r;
    case (kind_r)
      KIND_INS_FRONT: begin
        if (count_r != FULL_CNT) begin
          ok        = 1'b1;
          act       = ACT_SHIFT_R;
          count_nxt = count_r + 1'b1;
        end
      end
      KIND_INS_BACK: begin
        if (count_r != FULL_CNT) begin
          ok        = 1'b1;
          act       = ACT_PUT_TAIL;
          count_nxt = count_r + 1'b1;
        end
      end
      KIND_SEARCH: begin
        ok = found;
      end
      KIND_REM_VALUE: begin
        if (found) begin
          ok        = 1'b1;
          act       = ACT_SHL_HIT;
          count_nxt = count_r - 1'b1;
        end
      end
      KIND_REM_FRONT: begin
        if (count_r != '0) begin
          ok        = 1'b1;
          act       = ACT_SHIFT_L;
          count_nxt = count_r - 1'b1;
        end
      end
      KIND_REM_BACK: begin
        // the back entry is simply dropped from the count
        if (count_r != '0) begin
          ok        = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Broadcast to the row: compare in ST_CMP, act only when apply fires
  always_comb begin
    cmd.cmp   = (state_r == ST_CMP);
    cmd.act   = apply_fire ? act : ACT_HOLD;
    cmd.value = value_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_xfer) state_nxt = ST_CMP;
      ST_CMP:   state_nxt = ST_APPLY;
      ST_APPLY: if (apply_fire) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (apply_fire) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (apply_fire) count_r <= count_nxt;
    end
  end

  // Payload registers: capture the operand and the result
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r  <= in_kind;
      value_r <= in_value;
    end
    if (apply_fire) begin
      out_ok_r    <= ok;
      out_count_r <= COUNT_W'(count_nxt);
    end
  end

  // Row of cells: each cell holds one position, neighbors feed shifts
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [VALUE_W-1:0] left_d;
    logic [VALUE_W-1:0] right_d;

    if (k == 0) begin : g_first
      assign left_d       = value_r;
      assign hit_before_w[k] = 1'b0;
    end else begin : g_inner
      assign left_d       = entry_w[k-1];
      assign hit_before_w[k] = |match_w[k-1:0];
    end

    if (k == DEPTH - 1) begin : g_last
      assign right_d = entry_w[k];
    end else begin : g_mid
      assign right_d = entry_w[k+1];
    end

    ble_cell #(
      .DEPTH (DEPTH),
      .IDX   (k)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count_r),
      .left_in    (left_d),
      .right_in   (right_d),
      .hit_before (hit_before_w[k]),
      .entry      (entry_w[k]),
      .match      (match_w[k])
    );
  end

  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;
  assign out_count = out_count_r;

endmodule
